>>> rtl/strmm_pkg.sv
// Shared types and constants for the segment tree range min/max block.
// No dependencies; imported by every module of the block.
`default_nettype none

package strmm_pkg;

    localparam int LEAVES    = 1024;
    localparam int IDX_W     = 10;
    localparam int DATA_W    = 32;
    localparam int LEAF_W    = (LEAVES > 1) ? $clog2(LEAVES) : 1;
    localparam int LEAF_BASE = 1 << LEAF_W;
    localparam int NODE_W    = LEAF_W + 1;
    localparam int TREE_SIZE = 2 * LEAF_BASE;
    // leaf/node pointer, wide enough for base + any index + 1
    localparam int PTR_W     = ((NODE_W > IDX_W) ? NODE_W : IDX_W) + 1;

    typedef enum logic [1:0] {
        OP_SET   = 2'd0,
        OP_ADD   = 2'd1,
        OP_QUERY = 2'd2
    } t_op;

    typedef struct packed {
        logic signed [DATA_W-1:0] max_v;
        logic signed [DATA_W-1:0] min_v;
    } t_node;

    localparam logic signed [DATA_W-1:0] VAL_LOWEST  = {1'b1, {(DATA_W-1){1'b0}}};
    localparam logic signed [DATA_W-1:0] VAL_HIGHEST = {1'b0, {(DATA_W-1){1'b1}}};

endpackage

`default_nettype wire

>>> rtl/strmm_minmax.sv
// Shared compare unit: merges two (max, min) pairs into one.
// Depends on strmm_pkg.
`default_nettype none

module strmm_minmax (
    input  wire strmm_pkg::t_node i_a,
    input  wire strmm_pkg::t_node i_b,
    output strmm_pkg::t_node      o_y
);
    import strmm_pkg::*;

    always_comb begin
        o_y.max_v = ($signed(i_a.max_v) > $signed(i_b.max_v)) ? i_a.max_v : i_b.max_v;
        o_y.min_v = ($signed(i_a.min_v) < $signed(i_b.min_v)) ? i_a.min_v : i_b.min_v;
    end

endmodule

`default_nettype wire

>>> rtl/segment_tree_range_min_max.sv
// Top level of the segment tree range min/max block: sequencer, node memory.
// Depends on strmm_pkg and strmm_minmax.
`default_nettype none

// Segment tree over LEAVES signed 32-bit values, each tree node holding the
// max and min of its interval. A command is taken when start is high and busy
// is low. Set (op 0) and add (op 1) rewrite one leaf and refresh the path to
// the root; they give no result. Query (op 2) gives one result: o_valid is
// high for exactly one cycle with o_range_max / o_range_min of the inclusive
// range [index_low, index_high] (index_high saturates at LEAVES-1; an empty
// range returns max = most negative, min = most positive). There is no way to
// hold a result off: the receiver must take it in that cycle. Op 3 and a set
// or add beyond the last leaf are dropped. After reset the block runs a
// clearing pass that zeroes all TREE_SIZE nodes, busy throughout.
// The node memory (one read, one write per cycle) and the one shared min/max
// compare unit set the pace of each operation:
//   set / add : the leaf write, then one tree level per cycle up to the root;
//               the sibling read overlaps the parent write.
//   query     : per level, an odd left or right pointer folds in its node,
//               then both step up until they meet; o_valid rises the cycle
//               busy drops.
// Tree layout is a heap: node 1 is the root, children of n are 2n and 2n+1,
// leaf i sits at LEAF_BASE + i. Queries walk bottom-up with a half-open
// [l, r) pointer pair, reading one node per cycle.
module segment_tree_range_min_max (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          start,
    output      logic                          busy,
    input  wire logic [1:0]                    i_op,
    input  wire logic [strmm_pkg::IDX_W-1:0]   i_index_low,
    input  wire logic [strmm_pkg::IDX_W-1:0]   i_index_high,
    input  wire logic signed [strmm_pkg::DATA_W-1:0] i_amount,
    output      logic                          o_valid,
    output      logic signed [strmm_pkg::DATA_W-1:0] o_range_max,
    output      logic signed [strmm_pkg::DATA_W-1:0] o_range_min
);
    import strmm_pkg::*;

    typedef enum logic [4:0] {
        S_CLEAR = 5'b00001,
        S_IDLE  = 5'b00010,
        S_LEAF  = 5'b00100,
        S_UP    = 5'b01000,
        S_QRY   = 5'b10000
    } t_state;

    localparam logic [PTR_W-1:0] P_BASE = PTR_W'(LEAF_BASE);
    localparam logic [PTR_W-1:0] P_LAST = PTR_W'(LEAVES - 1);
    localparam logic [PTR_W-1:0] P_CNT  = PTR_W'(LEAVES);
    localparam logic [PTR_W-1:0] P_ONE  = PTR_W'(1);
    localparam logic [NODE_W-1:0] A_ROOT = NODE_W'(1);

    // node memory
    t_node r_mem [TREE_SIZE];
    t_node r_rd_q;

    t_state r_state, n_state;
    logic [NODE_W-1:0] r_clr, n_clr;
    logic [NODE_W-1:0] r_pos, n_pos;
    logic [PTR_W-1:0]  r_l, n_l;
    logic [PTR_W-1:0]  r_r, n_r;
    logic              r_pend, n_pend;
    logic              r_is_add, n_is_add;
    logic signed [DATA_W-1:0] r_amount, n_amount;
    t_node             r_cur, n_cur;
    t_node             r_acc, n_acc;
    logic              r_valid, n_valid;
    t_node             r_res, n_res;

    logic              mem_we;
    logic [NODE_W-1:0] mem_wa;
    t_node             mem_wd;
    logic [NODE_W-1:0] mem_ra;

    t_node             mm_a, mm_y;
    logic [PTR_W-1:0]  idx_lo, idx_hi, hi_sat;
    logic [NODE_W-1:0] parent;
    logic signed [DATA_W-1:0] leaf_v;

    strmm_minmax u_minmax (
        .i_a (mm_a),
        .i_b (r_rd_q),
        .o_y (mm_y)
    );

    assign busy        = (r_state != S_IDLE);
    assign o_valid     = r_valid;
    assign o_range_max = r_res.max_v;
    assign o_range_min = r_res.min_v;

    assign idx_lo = PTR_W'(i_index_low);
    assign idx_hi = PTR_W'(i_index_high);
    assign hi_sat = (idx_hi > P_LAST) ? P_LAST : idx_hi;
    assign parent = r_pos >> 1;
    assign leaf_v = r_is_add ? (r_rd_q.max_v + r_amount) : r_amount;
    // the compare unit folds into the query accumulator or up the update path
    assign mm_a   = (r_state == S_QRY) ? r_acc : r_cur;

    always_comb begin
        n_state  = r_state;
        n_clr    = r_clr;
        n_pos    = r_pos;
        n_l      = r_l;
        n_r      = r_r;
        n_pend   = 1'b0;
        n_is_add = r_is_add;
        n_amount = r_amount;
        n_cur    = r_cur;
        n_acc    = r_acc;
        n_valid  = 1'b0;
        n_res    = r_res;
        mem_we   = 1'b0;
        mem_wa   = r_pos;
        mem_wd   = r_cur;
        mem_ra   = r_pos ^ NODE_W'(1);

        case (r_state)
            S_CLEAR: begin
                mem_we = 1'b1;
                mem_wa = r_clr;
                mem_wd = '0;
                n_clr  = r_clr + NODE_W'(1);
                if (r_clr == {NODE_W{1'b1}}) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                // fetch the addressed leaf ahead of a set or add transfer
                mem_ra = NODE_W'(P_BASE + idx_lo);
                if (start) begin
                    case (i_op)
                        OP_SET, OP_ADD: begin
                            if (idx_lo < P_CNT) begin
                                n_pos    = NODE_W'(P_BASE + idx_lo);
                                n_is_add = (i_op == OP_ADD);
                                n_amount = i_amount;
                                n_state  = S_LEAF;
                            end
                        end
                        OP_QUERY: begin
                            n_l         = P_BASE + idx_lo;
                            n_r         = P_BASE + hi_sat + P_ONE;
                            n_acc.max_v = VAL_LOWEST;
                            n_acc.min_v = VAL_HIGHEST;
                            n_state     = S_QRY;
                        end
                        default: begin
                            n_state = S_IDLE;
                        end
                    endcase
                end
            end
            S_LEAF: begin
                // leaf read is back; write new leaf, fetch its sibling
                mem_we      = 1'b1;
                mem_wa      = r_pos;
                mem_wd      = '{max_v: leaf_v, min_v: leaf_v};
                mem_ra      = r_pos ^ NODE_W'(1);
                n_cur       = '{max_v: leaf_v, min_v: leaf_v};
                n_state     = S_UP;
            end
            S_UP: begin
                // sibling is back; write parent, fetch parent's sibling
                mem_we = 1'b1;
                mem_wa = parent;
                mem_wd = mm_y;
                mem_ra = parent ^ NODE_W'(1);
                n_cur  = mm_y;
                n_pos  = parent;
                if (parent == A_ROOT) begin
                    n_state = S_IDLE;
                end
            end
            S_QRY: begin
                if (r_pend) begin
                    n_acc = mm_y;
                end
                mem_ra = r_l[NODE_W-1:0];
                if (r_l >= r_r) begin
                    n_res   = r_pend ? mm_y : r_acc;
                    n_valid = 1'b1;
                    n_state = S_IDLE;
                end else if (r_l[0]) begin
                    mem_ra = r_l[NODE_W-1:0];
                    n_pend = 1'b1;
                    n_l    = r_l + P_ONE;
                end else if (r_r[0]) begin
                    mem_ra = NODE_W'(r_r - P_ONE);
                    n_pend = 1'b1;
                    n_r    = r_r - P_ONE;
                end else begin
                    n_l = r_l >> 1;
                    n_r = r_r >> 1;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_wa] <= mem_wd;
        end
        r_rd_q <= r_mem[mem_ra];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_clr   <= '0;
            r_pend  <= 1'b0;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_clr   <= n_clr;
            r_pend  <= n_pend;
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pos    <= n_pos;
        r_l      <= n_l;
        r_r      <= n_r;
        r_is_add <= n_is_add;
        r_amount <= n_amount;
        r_cur    <= n_cur;
        r_acc    <= n_acc;
        r_res    <= n_res;
    end

endmodule

`default_nettype wire

>>> rtl/strmm_checker.sv
// Port-level checks for the segment tree range min/max block, and its bind.
// Depends on strmm_pkg and segment_tree_range_min_max.
`default_nettype none

module strmm_checker (
    input wire logic                                 i_clk,
    input wire logic                                 i_rst_n,
    input wire logic                                 start,
    input wire logic                                 busy,
    input wire logic [1:0]                           i_op,
    input wire logic                                 o_valid,
    input wire logic signed [strmm_pkg::DATA_W-1:0]  o_range_max,
    input wire logic signed [strmm_pkg::DATA_W-1:0]  o_range_min
);
    import strmm_pkg::*;

    // a query transfer always makes the block busy
    a_query_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_op == OP_QUERY) |=> busy)
        else $error("query accepted but block not busy");

    // a result only ends a busy stretch
    a_valid_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(busy))
        else $error("result without preceding work");

    // one result per query: no back-to-back strobes
    a_single_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid)
        else $error("result strobe held two cycles");

    // a non-empty range has min <= max
    a_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !(o_range_max == VAL_LOWEST && o_range_min == VAL_HIGHEST))
        |-> ($signed(o_range_min) <= $signed(o_range_max)))
        else $error("range min above range max");

endmodule

bind segment_tree_range_min_max strmm_checker u_strmm_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .start       (start),
    .busy        (busy),
    .i_op        (i_op),
    .o_valid     (o_valid),
    .o_range_max (o_range_max),
    .o_range_min (o_range_min)
);

`default_nettype wire
